// ===== hw/rtl/prog_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package prog_pkg;

   // configuration register indexes
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_ADDR_W-1:0] CSR_CENTER_X      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROW_SPACING   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROW_TOLERANCE = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_HALF_ROWS     = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_VANISH_HEIGHT = 3'd5;

   // steering codes
   localparam logic [1:0] STEER_STOP  = 2'd0;
   localparam logic [1:0] STEER_RIGHT = 2'd1;
   localparam logic [1:0] STEER_LEFT  = 2'd2;

   // internal widths, sized for the widest coordinate the block supports
   localparam int CRD_W       = 17;   // coordinate, zero-extended
   localparam int PX_W        = 18;   // signed image-centered coordinate
   localparam int AX_W        = 20;   // |px| in Q.4
   localparam int A_W         = 33;   // 16 * spacing * (vanish - py)
   localparam int RATIO_MAG_W = 15;   // |ratio| never exceeds 0.5 in Q1.15
   localparam int NEAR_W      = 24;   // signed nearest line before saturation
   localparam int NMAG_W      = 22;

   typedef struct packed {
      logic load;
      logic mul;
      logic diva_start;
      logic walk_init;
      logic step;
      logic check_adv;
      logic match;
      logic divr_start;
      logic ratio_cap;
      logic tol;
      logic acc;
      logic avg_start;
      logic avg_cap;
      logic fin;
      logic out_load;
   } prog_cmd_type;

   typedef struct packed {
      logic present;
      logic fend;
      logic div_done;
      logic n_zero;
      logic hit;
      logic k_last;
      logic cnt_zero;
   } prog_sts_type;

endpackage

`default_nettype wire

// ===== hw/rtl/prog_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle. The dividend is taken
// MSB first; rem_init lets a scaled numerator start in the remainder.
module prog_div #(
   parameter int DVW = 33,
   parameter int DSW = 37
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [DSW-1:0]               rem_init,
   input  wire logic [DVW-1:0]               dividend,
   input  wire logic [DSW-1:0]               divisor,
   input  wire logic [$clog2(DVW+1)-1:0]     steps,
   output logic      [DVW-1:0]               quotient,
   output logic      [DSW-1:0]               remainder,
   output logic                              done
);
   localparam int STW = $clog2(DVW+1);

   logic [DSW-1:0] rem_ff, rem_in;
   logic [DVW-1:0] dvd_ff, dvd_in;
   logic [DVW-1:0] quo_ff, quo_in;
   logic [DSW-1:0] dsr_ff, dsr_in;
   logic [STW-1:0] cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [DSW:0]   trial;
   logic [DSW:0]   diff;
   logic           ge;

   always_comb begin
      trial   = {rem_ff, dvd_ff[DVW-1]};
      diff    = trial - {1'b0, dsr_ff};
      ge      = trial >= {1'b0, dsr_ff};
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = rem_init;
         dvd_in  = dividend;
         quo_in  = '0;
         dsr_in  = divisor;
         cnt_in  = steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DSW-1:0] : trial[DSW-1:0];
         dvd_in = {dvd_ff[DVW-2:0], 1'b0};
         quo_in = {quo_ff[DVW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/prog_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module prog_dp
   import prog_pkg::*;
#(
   parameter int MAX_HALF_ROWS = 8,
   parameter int COORD_BITS    = 12,
   parameter int MAX_PLANTS    = 255
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   req_plant_present,
   input  wire logic [COORD_BITS-1:0]  req_plant_x,
   input  wire logic [COORD_BITS-1:0]  req_plant_y,
   input  wire logic                   req_frame_end,
   input  wire prog_cmd_type           cmd,
   output prog_sts_type                sts,
   output logic                        rsp_matched,
   output logic signed [17:0]          rsp_nearest_line_x,
   output logic signed [16:0]          rsp_offset_px,
   output logic        [16:0]          rsp_line_gap,
   output logic signed [15:0]          rsp_offset_ratio,
   output logic                        rsp_plant_in_tolerance,
   output logic                        rsp_frame_done,
   output logic signed [15:0]          rsp_average_ratio,
   output logic                        rsp_within_threshold,
   output logic        [1:0]           rsp_steer_direction
);
   localparam int KW   = $clog2(MAX_HALF_ROWS + 1);
   localparam int LW   = A_W + KW;
   localparam int CNW  = $clog2(MAX_PLANTS + 1);
   localparam int SUMW = RATIO_MAG_W + 1 + CNW;
   localparam int SMW  = SUMW - 1;
   localparam int STW  = $clog2(A_W + 1);
   localparam int TPW  = RATIO_MAG_W + 12;

   // configuration
   logic [11:0] cx_ff, sp_ff, tol_ff;
   logic [12:0] fh_ff;
   logic [3:0]  hrc_ff;
   logic [15:0] vh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff  <= 12'd320;
         fh_ff  <= 13'd480;
         sp_ff  <= 12'd100;
         tol_ff <= 12'd20;
         hrc_ff <= 4'd3;
         vh_ff  <= 16'd1000;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_CENTER_X:      cx_ff  <= csr_wdata[11:0];
            CSR_FRAME_HEIGHT:  fh_ff  <= csr_wdata[12:0];
            CSR_ROW_SPACING:   sp_ff  <= csr_wdata[11:0];
            CSR_ROW_TOLERANCE: tol_ff <= csr_wdata[11:0];
            CSR_HALF_ROWS:     hrc_ff <= csr_wdata[3:0];
            CSR_VANISH_HEIGHT: vh_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   logic [15:0]   veff;
   logic [KW-1:0] n_lines;

   always_comb begin
      veff = (vh_ff == 16'd0) ? 16'd1 : vh_ff;
      if (int'(hrc_ff) > MAX_HALF_ROWS) n_lines = KW'(MAX_HALF_ROWS);
      else n_lines = KW'(hrc_ff);
   end

   // per-item registers
   logic                    present_ff, fend_ff, px_neg_ff;
   logic [AX_W-1:0]         ax_ff;
   logic signed [PX_W-1:0]  py_ff;
   logic [A_W-1:0]          a_ff;
   logic [A_W-1:0]          q_ff;
   logic [15:0]             r_ff;
   logic [15:0]             rr_ff;
   logic [LW-1:0]           base_ff, x1_ff, x2_ff, gap_ff;
   logic [KW-1:0]           k_ff;
   logic                    matched_ff;
   logic signed [NEAR_W-1:0] near_ff;
   logic [AX_W-1:0]         offs_mag_ff;
   logic                    offs_neg_ff;
   logic [RATIO_MAG_W-1:0]  ratio_mag_ff, avg_mag_ff;
   logic signed [15:0]      ratio_ff, avg_ff;
   logic                    in_tol_ff, within_ff;
   logic [1:0]              steer_ff;
   logic [CNW-1:0]          cnt_ff;
   logic signed [SUMW-1:0]  sum_ff;

   // load
   logic [CRD_W-1:0]       x_ext, y_ext;
   logic signed [PX_W-1:0] px, px_abs, py;

   always_comb begin
      x_ext  = CRD_W'(req_plant_x);
      y_ext  = CRD_W'(req_plant_y);
      px     = $signed({1'b0, x_ext}) - $signed({6'b0, cx_ff});
      px_abs = px[PX_W-1] ? -px : px;
      py     = $signed({5'b0, fh_ff}) - $signed({1'b0, y_ext});
   end

   // line scale A = 16 * spacing * (vanish - py), zero when the lines fold to the center
   logic signed [PX_W:0] vm;
   logic [A_W-1:0]       a_prod;

   always_comb begin
      vm     = $signed({3'b0, veff}) - $signed({py_ff[PX_W-1], py_ff});
      a_prod = {sp_ff, 4'b0} * vm[16:0];
   end

   // line walk: x_k = k*q + floor(k*r/v) + round bit, tracked incrementally
   logic [16:0]   rr_sum;
   logic          wrap, rnd;
   logic [15:0]   rr_nx;
   logic [LW-1:0] base_nx, x2_nx, ax_l;

   always_comb begin
      rr_sum  = {1'b0, rr_ff} + {1'b0, r_ff};
      wrap    = rr_sum >= {1'b0, veff};
      rr_nx   = wrap ? 16'(rr_sum - {1'b0, veff}) : rr_sum[15:0];
      base_nx = base_ff + LW'(q_ff) + LW'(wrap);
      rnd     = {rr_nx, 1'b0} >= {1'b0, veff};
      x2_nx   = base_nx + LW'(rnd);
      ax_l    = LW'(ax_ff);
   end

   // match
   logic [AX_W-1:0]          d1;
   logic [LW-1:0]            d2;
   logic                     pick_x1;
   logic [NMAG_W-1:0]        near_mag;
   logic signed [NEAR_W-1:0] near_signed, near_full;

   always_comb begin
      d1       = ax_ff - x1_ff[AX_W-1:0];
      d2       = x2_ff - ax_l;
      pick_x1  = LW'(d1) < d2;
      near_mag = pick_x1 ? NMAG_W'(x1_ff[AX_W-1:0]) : x2_ff[NMAG_W-1:0];
      near_signed = px_neg_ff ? -$signed({2'b0, near_mag}) : $signed({2'b0, near_mag});
      near_full   = near_signed + $signed({8'b0, cx_ff, 4'b0});
   end

   // shared divider
   logic [A_W-1:0]          div_quo;
   logic [LW-1:0]           div_rem;
   logic                    div_done;
   logic                    div_start;
   logic [LW-1:0]           div_rem_init, div_divisor;
   logic [A_W-1:0]          div_dividend;
   logic [STW-1:0]          div_steps;
   logic signed [SUMW-1:0]  sum_negated;
   logic [SMW-1:0]          sum_mag;

   always_comb begin
      sum_negated = -sum_ff;
      sum_mag     = sum_ff[SUMW-1] ? sum_negated[SMW-1:0] : sum_ff[SMW-1:0];
      div_start   = cmd.diva_start | cmd.divr_start | cmd.avg_start;
      if (cmd.diva_start) begin
         div_rem_init = '0;
         div_dividend = a_ff;
         div_divisor  = LW'(veff);
         div_steps    = STW'(A_W);
      end else if (cmd.divr_start) begin
         // |offset| * 2^15 / gap: numerator held in the remainder
         div_rem_init = LW'(offs_mag_ff);
         div_dividend = '0;
         div_divisor  = gap_ff;
         div_steps    = STW'(RATIO_MAG_W);
      end else begin
         div_rem_init = '0;
         div_dividend = A_W'(sum_mag) << (A_W - SMW);
         div_divisor  = LW'(cnt_ff);
         div_steps    = STW'(SMW);
      end
   end

   prog_div #(
      .DVW(A_W),
      .DSW(LW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .rem_init  (div_rem_init),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .steps     (div_steps),
      .quotient  (div_quo),
      .remainder (div_rem),
      .done      (div_done)
   );

   logic [RATIO_MAG_W-1:0] rq;
   logic [TPW-1:0]         tol_prod, avg_prod;

   always_comb begin
      rq       = div_quo[RATIO_MAG_W-1:0];
      tol_prod = ratio_mag_ff * sp_ff;
      avg_prod = avg_mag_ff * sp_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         present_ff   <= req_plant_present;
         fend_ff      <= req_frame_end;
         px_neg_ff    <= px[PX_W-1];
         ax_ff        <= {px_abs[15:0], 4'b0};
         py_ff        <= py;
         matched_ff   <= 1'b0;
         near_ff      <= '0;
         offs_mag_ff  <= '0;
         offs_neg_ff  <= 1'b0;
         gap_ff       <= '0;
         ratio_ff     <= '0;
         ratio_mag_ff <= '0;
         in_tol_ff    <= 1'b0;
         avg_ff       <= '0;
         avg_mag_ff   <= '0;
         within_ff    <= 1'b0;
         steer_ff     <= STEER_STOP;
      end
      if (cmd.mul) begin
         a_ff <= (!vm[PX_W] && vm != '0) ? a_prod : '0;
      end
      if (cmd.walk_init) begin
         q_ff    <= div_quo;
         r_ff    <= div_rem[15:0];
         rr_ff   <= '0;
         base_ff <= '0;
         x1_ff   <= '0;
         k_ff    <= KW'(1);
      end
      if (cmd.step) begin
         rr_ff   <= rr_nx;
         base_ff <= base_nx;
         x2_ff   <= x2_nx;
      end
      if (cmd.check_adv) begin
         x1_ff <= x2_ff;
         k_ff  <= k_ff + 1'b1;
      end
      if (cmd.match) begin
         matched_ff  <= 1'b1;
         near_ff     <= near_full;
         offs_mag_ff <= pick_x1 ? d1 : d2[AX_W-1:0];
         offs_neg_ff <= (!pick_x1) ^ px_neg_ff;
         gap_ff      <= x2_ff - x1_ff;
      end
      if (cmd.ratio_cap) begin
         ratio_mag_ff <= rq;
         ratio_ff     <= offs_neg_ff ? -$signed({1'b0, rq}) : $signed({1'b0, rq});
      end
      if (cmd.tol) begin
         in_tol_ff <= tol_prod < {tol_ff, 15'b0};
      end
      if (cmd.avg_cap) begin
         avg_mag_ff <= rq;
         avg_ff     <= sum_ff[SUMW-1] ? -$signed({1'b0, rq}) : $signed({1'b0, rq});
      end
      if (cmd.fin) begin
         within_ff <= avg_prod[TPW-1:15] < tol_ff;
         if (avg_prod[TPW-1:15] < tol_ff) steer_ff <= STEER_STOP;
         else if (!avg_ff[15] && avg_ff != 16'sd0) steer_ff <= STEER_RIGHT;
         else steer_ff <= STEER_LEFT;
      end
   end

   // frame accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sum_ff <= '0;
      end else if (cmd.fin) begin
         cnt_ff <= '0;
         sum_ff <= '0;
      end else if (cmd.acc && present_ff && cnt_ff < CNW'(MAX_PLANTS)) begin
         cnt_ff <= cnt_ff + 1'b1;
         sum_ff <= sum_ff + {{(SUMW-16){ratio_ff[15]}}, ratio_ff};
      end
   end

   always_comb begin
      sts.present  = present_ff;
      sts.fend     = fend_ff;
      sts.div_done = div_done;
      sts.n_zero   = n_lines == '0;
      sts.hit      = (x1_ff < ax_l) && (ax_l < x2_ff);
      sts.k_last   = k_ff == n_lines;
      sts.cnt_zero = cnt_ff == '0;
   end

   // result register with saturation to field ranges
   logic signed [17:0]          near_sat;
   logic signed [16:0]          offs_sat;
   logic        [16:0]          gap_sat;
   logic signed [AX_W:0]        offs_neg_v;

   always_comb begin
      if (near_ff > 24'sd131071) near_sat = 18'sh1FFFF;
      else if (near_ff < -24'sd131072) near_sat = 18'sh20000;
      else near_sat = near_ff[17:0];
      offs_neg_v = -$signed({1'b0, offs_mag_ff});
      if (!offs_neg_ff) begin
         offs_sat = (offs_mag_ff > AX_W'(65535)) ? 17'sh0FFFF : $signed(offs_mag_ff[16:0]);
      end else begin
         offs_sat = (offs_mag_ff > AX_W'(65536)) ? 17'sh10000 : offs_neg_v[16:0];
      end
      gap_sat = (gap_ff > LW'(131071)) ? 17'h1FFFF : gap_ff[16:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_matched            <= matched_ff;
         rsp_nearest_line_x     <= near_sat;
         rsp_offset_px          <= offs_sat;
         rsp_line_gap           <= gap_sat;
         rsp_offset_ratio       <= ratio_ff;
         rsp_plant_in_tolerance <= in_tol_ff;
         rsp_frame_done         <= fend_ff;
         rsp_average_ratio      <= avg_ff;
         rsp_within_threshold   <= within_ff;
         rsp_steer_direction    <= steer_ff;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/prog_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module prog_ctrl
   import prog_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   input  wire prog_sts_type sts,
   output prog_cmd_type      cmd
);
   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_MUL    = 5'd1;
   localparam logic [4:0] S_DIVA   = 5'd2;
   localparam logic [4:0] S_DIVA_W = 5'd3;
   localparam logic [4:0] S_STEP   = 5'd4;
   localparam logic [4:0] S_CHECK  = 5'd5;
   localparam logic [4:0] S_DIVR   = 5'd6;
   localparam logic [4:0] S_DIVR_W = 5'd7;
   localparam logic [4:0] S_TOL    = 5'd8;
   localparam logic [4:0] S_ACC    = 5'd9;
   localparam logic [4:0] S_AVG    = 5'd10;
   localparam logic [4:0] S_AVG_W  = 5'd11;
   localparam logic [4:0] S_FIN    = 5'd12;
   localparam logic [4:0] S_OUT    = 5'd13;

   logic [4:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = sts.present ? S_DIVA : S_ACC;
         end
         S_DIVA: begin
            cmd.diva_start = 1'b1;
            state_in       = S_DIVA_W;
         end
         S_DIVA_W: begin
            if (sts.div_done) begin
               cmd.walk_init = 1'b1;
               state_in      = sts.n_zero ? S_ACC : S_STEP;
            end
         end
         S_STEP: begin
            cmd.step = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (sts.hit) begin
               cmd.match = 1'b1;
               state_in  = S_DIVR;
            end else begin
               cmd.check_adv = 1'b1;
               state_in      = sts.k_last ? S_ACC : S_STEP;
            end
         end
         S_DIVR: begin
            cmd.divr_start = 1'b1;
            state_in       = S_DIVR_W;
         end
         S_DIVR_W: begin
            if (sts.div_done) begin
               cmd.ratio_cap = 1'b1;
               state_in      = S_TOL;
            end
         end
         S_TOL: begin
            cmd.tol  = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            state_in = sts.fend ? S_AVG : S_OUT;
         end
         S_AVG: begin
            // an empty frame keeps the cleared average
            if (sts.cnt_zero) begin
               state_in = S_FIN;
            end else begin
               cmd.avg_start = 1'b1;
               state_in      = S_AVG_W;
            end
         end
         S_AVG_W: begin
            if (sts.div_done) begin
               cmd.avg_cap = 1'b1;
               state_in    = S_FIN;
            end
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_div_start_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.diva_start, cmd.divr_start, cmd.avg_start}))
      else $error("more than one divider start");

   a_out_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while held");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_MUL))
      else $error("accepted request did not start processing");

   a_walk_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVA_W && sts.div_done) |=> (state_ff == S_STEP || state_ff == S_ACC))
      else $error("line walk not entered after scale division");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/perspective_row_offset_guidance.sv =====
// Processing: a present plant runs the scale division and then walks the reference
//   lines; a matched plant adds the ratio division; an absent plant skips both.
//   A frame end request adds the averaging division, which an empty frame skips.
// Throughput: one request at a time, the next accepted in the cycle after the response
//   is loaded; the serial divider (one quotient bit per cycle) takes most of the time.
// Reset: synchronous, active high; restores config defaults and clears the frame sums.
`timescale 1ns / 1ps
`default_nettype none

module perspective_row_offset_guidance
   import prog_pkg::*;
#(
   parameter int MAX_HALF_ROWS = 8,
   parameter int COORD_BITS    = 12,
   parameter int MAX_PLANTS    = 255
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_plant_present,
   input  wire logic [COORD_BITS-1:0]  req_plant_x,
   input  wire logic [COORD_BITS-1:0]  req_plant_y,
   input  wire logic                   req_frame_end,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_matched,
   output logic signed [17:0]          rsp_nearest_line_x,
   output logic signed [16:0]          rsp_offset_px,
   output logic        [16:0]          rsp_line_gap,
   output logic signed [15:0]          rsp_offset_ratio,
   output logic                        rsp_plant_in_tolerance,
   output logic                        rsp_frame_done,
   output logic signed [15:0]          rsp_average_ratio,
   output logic                        rsp_within_threshold,
   output logic        [1:0]           rsp_steer_direction
);
   prog_cmd_type cmd;
   prog_sts_type sts;

   prog_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   prog_dp #(
      .MAX_HALF_ROWS (MAX_HALF_ROWS),
      .COORD_BITS    (COORD_BITS),
      .MAX_PLANTS    (MAX_PLANTS)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .csr_we                 (csr_we),
      .csr_addr               (csr_addr),
      .csr_wdata              (csr_wdata),
      .req_plant_present      (req_plant_present),
      .req_plant_x            (req_plant_x),
      .req_plant_y            (req_plant_y),
      .req_frame_end          (req_frame_end),
      .cmd                    (cmd),
      .sts                    (sts),
      .rsp_matched            (rsp_matched),
      .rsp_nearest_line_x     (rsp_nearest_line_x),
      .rsp_offset_px          (rsp_offset_px),
      .rsp_line_gap           (rsp_line_gap),
      .rsp_offset_ratio       (rsp_offset_ratio),
      .rsp_plant_in_tolerance (rsp_plant_in_tolerance),
      .rsp_frame_done         (rsp_frame_done),
      .rsp_average_ratio      (rsp_average_ratio),
      .rsp_within_threshold   (rsp_within_threshold),
      .rsp_steer_direction    (rsp_steer_direction)
   );

endmodule

`default_nettype wire

// ===== test/perspective_row_offset_guidance_tb.sv =====
`timescale 1ns / 1ps

module perspective_row_offset_guidance_tb;
   import prog_pkg::*;

   localparam int HALF_ROWS_MAX = 8;
   localparam int PLANTS_MAX    = 255;
   localparam int N_RANDOM      = 1030;

   typedef struct packed {
      logic               present;
      logic [11:0]        x;
      logic [11:0]        y;
      logic               fend;
   } plant_req_type;

   typedef struct packed {
      logic               matched;
      logic signed [17:0] near_x;
      logic signed [16:0] offs;
      logic [16:0]        gap;
      logic signed [15:0] ratio;
      logic               in_tol;
      logic               done;
      logic signed [15:0] avg;
      logic               thresh_ok;
      logic [1:0]         steer;
   } guide_rsp_type;

   typedef struct {
      plant_req_type req;
      logic          has_exp;
      guide_rsp_type exp;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_plant_present = 1'b0;
   logic [11:0] req_plant_x = '0;
   logic [11:0] req_plant_y = '0;
   logic req_frame_end = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_matched;
   logic signed [17:0] rsp_nearest_line_x;
   logic signed [16:0] rsp_offset_px;
   logic [16:0] rsp_line_gap;
   logic signed [15:0] rsp_offset_ratio;
   logic rsp_plant_in_tolerance;
   logic rsp_frame_done;
   logic signed [15:0] rsp_average_ratio;
   logic rsp_within_threshold;
   logic [1:0] rsp_steer_direction;

   perspective_row_offset_guidance u_dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_plant_present(req_plant_present), .req_plant_x(req_plant_x),
      .req_plant_y(req_plant_y), .req_frame_end(req_frame_end),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_matched(rsp_matched), .rsp_nearest_line_x(rsp_nearest_line_x),
      .rsp_offset_px(rsp_offset_px), .rsp_line_gap(rsp_line_gap),
      .rsp_offset_ratio(rsp_offset_ratio),
      .rsp_plant_in_tolerance(rsp_plant_in_tolerance),
      .rsp_frame_done(rsp_frame_done), .rsp_average_ratio(rsp_average_ratio),
      .rsp_within_threshold(rsp_within_threshold),
      .rsp_steer_direction(rsp_steer_direction)
   );

   always #6 clock = ~clock;

   // guidance settings and frame sums mirrored from the block
   longint g_center, g_height, g_spacing, g_tol, g_half, g_vanish;
   longint g_sum, g_count;

   guide_rsp_type expected_q[$];
   int  n_errors = 0;
   bit  rx_hold = 1'b0;
   bit  no_idle = 1'b0;

   function automatic longint fdiv(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic guide_rsp_type predict_guidance(plant_req_type r);
      guide_rsp_type o;
      longint px, py, ax, v, x1, x2, d1, d2, nx, of, gp, rt, av, pxo, n;
      bit hit;
      o = '0;
      hit = 0; nx = 0; of = 0; gp = 0; rt = 0;
      if (r.present) begin
         px = longint'(r.x) - g_center;
         py = g_height - longint'(r.y);
         ax = (px < 0 ? -px : px) * 16;
         v  = g_vanish == 0 ? 1 : g_vanish;
         n  = g_half > HALF_ROWS_MAX ? HALF_ROWS_MAX : g_half;
         x1 = 0;
         for (longint k = 1; k <= n && !hit; k++) begin
            x2 = fdiv(2 * (16 * k * g_spacing * (v - py)) + v, 2 * v);
            if (x1 < ax && ax < x2) begin
               d1 = ax - x1; d2 = x2 - ax;
               hit = 1;
               if (d1 < d2) begin nx = x1; of = d1; end
               else begin nx = x2; of = -d2; end
               gp = x2 - x1;
               if (px < 0) begin nx = -nx; of = -of; end
               nx += g_center * 16;
               rt = of * 32768 / gp;
               o.in_tol = ((rt < 0 ? -rt : rt) * g_spacing) < g_tol * 32768;
            end else begin
               x1 = x2;
            end
         end
         if (g_count < PLANTS_MAX) begin
            g_count++;
            g_sum += rt;
         end
      end
      o.matched = hit;
      o.near_x = 18'(clip(nx, -131072, 131071));
      o.offs   = 17'(clip(of, -65536, 65535));
      o.gap    = 17'(clip(gp, 0, 131071));
      o.ratio  = 16'(clip(rt, -32768, 32767));
      if (r.fend) begin
         av = g_count == 0 ? 0 : g_sum / g_count;
         av = clip(av, -32768, 32767);
         pxo = av * g_spacing / 32768;
         if (pxo < 0) pxo = -pxo;
         o.done = 1;
         o.avg = 16'(av);
         o.thresh_ok = pxo < g_tol;
         o.steer = o.thresh_ok ? STEER_STOP : (av > 0 ? STEER_RIGHT : STEER_LEFT);
         g_sum = 0; g_count = 0;
      end
      return o;
   endfunction

   task automatic csr_write(logic [CSR_ADDR_W-1:0] a, longint val);
      @(posedge clock);
      csr_we <= 1'b1; csr_addr <= a; csr_wdata <= val[15:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (a)
         CSR_CENTER_X:      g_center  = val & 12'hfff;
         CSR_FRAME_HEIGHT:  g_height  = val & 13'h1fff;
         CSR_ROW_SPACING:   g_spacing = val & 12'hfff;
         CSR_ROW_TOLERANCE: g_tol     = val & 12'hfff;
         CSR_HALF_ROWS:     g_half    = val & 4'hf;
         CSR_VANISH_HEIGHT: g_vanish  = val & 16'hffff;
         default: ;
      endcase
   endtask

   task automatic set_geometry(longint c, longint h, longint s, longint t, longint n, longint v);
      csr_write(CSR_CENTER_X, c);
      csr_write(CSR_FRAME_HEIGHT, h);
      csr_write(CSR_ROW_SPACING, s);
      csr_write(CSR_ROW_TOLERANCE, t);
      csr_write(CSR_HALF_ROWS, n);
      csr_write(CSR_VANISH_HEIGHT, v);
   endtask

   // sender: offer one request, wait for its acceptance; valid drops only on idling
   task automatic send_plant(plant_req_type r, bit typed, guide_rsp_type typed_exp);
      guide_rsp_type p;
      if (!no_idle && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < 13) @(posedge clock);
      end
      p = predict_guidance(r);
      if (typed && p !== typed_exp) begin
         n_errors++;
         $display("table row disagrees: %h vs %h", typed_exp, p);
      end
      expected_q.insert(expected_q.size(), p);
      req_valid <= 1'b1;
      req_plant_present <= r.present; req_plant_x <= r.x;
      req_plant_y <= r.y; req_frame_end <= r.fend;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain;
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (expected_q.size() != 0 && guard < 200000) begin
         @(posedge clock); guard++;
      end
      repeat (150) @(posedge clock);
   endtask

   function automatic plant_req_type rand_plant(int fend_pct);
      plant_req_type r;
      longint dx;
      r.present = $urandom_range(99) < 93;
      if ($urandom_range(3) == 0) r.x = 12'($urandom);
      else begin
         dx = longint'($urandom_range(32'(2 * (g_spacing * 4 + 8)))) - (g_spacing * 4 + 8);
         r.x = 12'(clip(g_center + dx, 0, 4095));
      end
      if ($urandom_range(3) == 0) r.y = 12'($urandom);
      else r.y = 12'(clip(g_height - longint'($urandom_range(600)), 0, 4095));
      r.fend = $urandom_range(99) < fend_pct;
      return r;
   endfunction

   // receiver
   always @(posedge clock) begin
      guide_rsp_type got, want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_matched, rsp_nearest_line_x, rsp_offset_px, rsp_line_gap,
                    rsp_offset_ratio, rsp_plant_in_tolerance, rsp_frame_done,
                    rsp_average_ratio, rsp_within_threshold, rsp_steer_direction};
            if (expected_q.size() == 0) begin
               n_errors++;
               if (n_errors <= 10) $display("unexpected response %h", got);
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  n_errors++;
                  if (n_errors <= 10)
                     $display("mismatch: exp m%0d nx%0d of%0d g%0d r%0d t%0d d%0d a%0d w%0d s%0d got m%0d nx%0d of%0d g%0d r%0d t%0d d%0d a%0d w%0d s%0d",
                        want.matched, want.near_x, want.offs, want.gap, want.ratio,
                        want.in_tol, want.done, want.avg, want.thresh_ok, want.steer,
                        got.matched, got.near_x, got.offs, got.gap, got.ratio,
                        got.in_tol, got.done, got.avg, got.thresh_ok, got.steer);
               end
            end
         end
         rsp_ready <= !rx_hold && (no_idle || $urandom_range(99) >= 13);
      end
   end

   // long receiver hold-off so the block backs up
   initial begin
      wait (!reset);
      repeat (3000) @(posedge clock);
      rx_hold = 1'b1;
      repeat (1500) @(posedge clock);
      rx_hold = 1'b0;
   end

   initial begin
      #60_000_000;
      $display("perspective_row_offset_guidance_tb NOT OK");
      $finish;
   end

   dir_row_type dir_tab[12];
   guide_rsp_type z;
   guide_rsp_type e_empty;

   initial begin
      plant_req_type r;
      g_center = 320; g_height = 480; g_spacing = 100; g_tol = 20;
      g_half = 3; g_vanish = 1000; g_sum = 0; g_count = 0;
      z = '0;
      e_empty = '0;
      e_empty.done = 1'b1;
      e_empty.thresh_ok = 1'b1;
      e_empty.steer = STEER_STOP;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty frame right after reset: average zero, stop
      dir_tab[0]  = '{'{1'b0, 12'd0, 12'd0, 1'b1}, 1'b1, e_empty};
      // plant on the center line at the bottom: ax = 0, nothing brackets it
      dir_tab[1]  = '{'{1'b1, 12'd320, 12'd480, 1'b0}, 1'b1, z};
      // bottom row: lines at 1600, 3200; plant at +10 px -> near x1=0, offset 160
      dir_tab[2]  = '{'{1'b1, 12'd330, 12'd480, 1'b0}, 1'b0, z};
      dir_tab[3]  = '{'{1'b1, 12'd250, 12'd480, 1'b0}, 1'b0, z};
      dir_tab[4]  = '{'{1'b1, 12'd420, 12'd480, 1'b0}, 1'b0, z};
      dir_tab[5]  = '{'{1'b1, 12'd4095, 12'd0, 1'b0}, 1'b0, z};
      dir_tab[6]  = '{'{1'b1, 12'd0, 12'd4095, 1'b0}, 1'b0, z};
      dir_tab[7]  = '{'{1'b1, 12'd0, 12'd0, 1'b0}, 1'b0, z};
      dir_tab[8]  = '{'{1'b1, 12'd4095, 12'd4095, 1'b1}, 1'b0, z};
      dir_tab[9]  = '{'{1'b1, 12'd345, 12'd470, 1'b1}, 1'b0, z};
      dir_tab[10] = '{'{1'b0, 12'hfff, 12'hfff, 1'b0}, 1'b0, z};
      dir_tab[11] = '{'{1'b1, 12'd290, 12'd400, 1'b1}, 1'b0, z};
      foreach (dir_tab[i]) send_plant(dir_tab[i].req, dir_tab[i].has_exp, dir_tab[i].exp);
      drain();

      // extremes: zero spacing, zero vanish height, too many lines
      set_geometry(4095, 4096, 0, 4095, 15, 0);
      send_plant('{1'b1, 12'd100, 12'd50, 1'b1}, 1'b0, z);
      drain();
      set_geometry(0, 1, 4095, 0, 8, 65535);
      for (int i = 0; i < 6; i++) begin
         r.present = 1; r.x = 12'($urandom); r.y = 12'($urandom_range(3)); r.fend = i == 5;
         send_plant(r, 1'b0, z);
      end
      drain();
      set_geometry(2048, 1024, 1, 4095, 0, 1);
      send_plant('{1'b1, 12'd2049, 12'd1, 1'b1}, 1'b0, z);
      drain();

      // random phases with varied geometry; one phase runs a long frame, still short of the count limit
      for (int ph = 0; ph < 6; ph++) begin
         set_geometry($urandom_range(4095), $urandom_range(1, 4096),
                      $urandom_range(1, 300), $urandom_range(0, 60),
                      $urandom_range(0, 15), $urandom_range(1, 65535));
         if (ph == 1) csr_write(CSR_VANISH_HEIGHT, $urandom_range(300, 4000));
         if (ph == 2) begin
            csr_write(CSR_CENTER_X, 320); csr_write(CSR_FRAME_HEIGHT, 480);
         end
         no_idle = (ph == 3);
         for (int i = 0; i < N_RANDOM / 6; i++) begin
            r = rand_plant(ph == 4 ? 0 : 8);
            if (ph == 4 && i == N_RANDOM / 6 - 1) r.fend = 1;
            send_plant(r, 1'b0, z);
         end
         r = rand_plant(100);
         send_plant(r, 1'b0, z);
         drain();
      end
      no_idle = 0;

      if (n_errors == 0 && expected_q.size() == 0) begin
         $display("perspective_row_offset_guidance_tb OK");
      end else begin
         $display("perspective_row_offset_guidance_tb NOT OK");
      end
      $finish;
   end

endmodule
